@@ sv/sb2dec_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants for the signed binary to decimal ASCII converter.
// No dependencies; imported by the divide unit and the top level.
package sb2dec_pkg;

  localparam int VALUE_WIDTH = 32;

  // tdata width of the input channel: value rounded up to whole bytes
  localparam int IN_TDATA_W = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int CHAR_W     = 8;

  // digits of the largest magnitude 2^(W-1): floor((W-1)*log10(2)) + 1
  localparam int MAX_DIGITS = (((VALUE_WIDTH - 1) * 1233) >> 12) + 1;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W      = $clog2(MAX_DIGITS);

  // reciprocal of ten: ceil(2^(W+4) / 10), exact for every W-bit dividend
  localparam int RECIP_SHIFT = VALUE_WIDTH + 4;
  localparam logic [VALUE_WIDTH+4:0] RECIP_POW = (VALUE_WIDTH + 5)'(1) << RECIP_SHIFT;
  localparam logic [VALUE_WIDTH:0] RECIP =
    (VALUE_WIDTH + 1)'((RECIP_POW + (VALUE_WIDTH + 5)'(9)) / (VALUE_WIDTH + 5)'(10));

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

endpackage

@@ sv/sb2dec_div10.sv @@
`timescale 1ns / 1ps
// Divide-by-ten unit: quotient by multiplication with a fixed reciprocal.
// Depends on sb2dec_pkg.
module sb2dec_div10 (
  input  logic [sb2dec_pkg::VALUE_WIDTH-1:0] dividend,
  output logic [sb2dec_pkg::VALUE_WIDTH-1:0] quotient
);
  import sb2dec_pkg::*;

  logic [2*VALUE_WIDTH:0] prod;

  assign prod     = {{VALUE_WIDTH{1'b0}}, dividend} * {{VALUE_WIDTH{1'b0}}, RECIP};
  assign quotient = {3'b000, prod[2*VALUE_WIDTH:RECIP_SHIFT]};

endmodule

@@ sv/signed_binary_to_decimal_ascii_top.sv @@
`timescale 1ns / 1ps
// Top level of the signed binary to decimal ASCII converter: sequencer,
// digit store and output register. Depends on sb2dec_pkg and sb2dec_div10.

// Each request on the input stream carries one two's-complement integer in
// in_tdata; the block answers with its decimal text on the output stream, one
// ASCII character per transfer, most significant digit first, a leading '-'
// for negative values, and out_tlast on the final digit. Zero gives a single
// '0' and the most negative value converts correctly through an unsigned
// magnitude. One shared divide-by-ten unit (a reciprocal multiply) yields one
// digit per cycle, then the characters leave (sign included) at full output
// rate unless out_tready is held low. in_tready is high only while the
// sequencer is idle; the final character of a number may still sit in the
// output register when the next value is taken.
module signed_binary_to_decimal_ascii_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [sb2dec_pkg::IN_TDATA_W-1:0]  in_tdata,   // [W-1:0] value
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [sb2dec_pkg::CHAR_W-1:0]      out_tdata,  // [7:0] char_code
  output logic                               out_tlast
);
  import sb2dec_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t                  state_r,     state_nxt;
  logic [VALUE_WIDTH-1:0]  mag_r,       mag_nxt;
  logic [3:0]              prev_r,      prev_nxt;
  logic                    have_prev_r, have_prev_nxt;
  logic                    neg_r,       neg_nxt;
  logic                    sign_pend_r, sign_pend_nxt;
  logic [CNT_W-1:0]        nd_r,        nd_nxt;
  logic [CNT_W-1:0]        rem_r,       rem_nxt;
  logic [3:0]              digits_r [MAX_DIGITS];
  logic                    out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]       out_char_r,  out_char_nxt;
  logic                    out_last_r,  out_last_nxt;

  logic [VALUE_WIDTH-1:0]  raw;
  logic [VALUE_WIDTH-1:0]  quot;
  logic [3:0]              ten_q_low;
  logic [3:0]              new_digit;
  logic [CNT_W-1:0]        rem_dec;
  logic [IDX_W-1:0]        rd_idx;
  logic                    in_acc;
  logic                    out_load;
  logic                    dig_we;

  sb2dec_div10 u_div10 (
    .dividend (mag_r),
    .quotient (quot)
  );

  assign raw     = in_tdata[VALUE_WIDTH-1:0];
  assign in_acc  = in_tvalid && in_tready;
  assign out_load = !out_valid_r || out_tready;

  // remainder from the previous step: low nibble of prev - 10 * quotient
  assign ten_q_low = {mag_r[2:0], 1'b0} + {mag_r[0], 3'b000};
  assign new_digit = prev_r - ten_q_low;

  assign rem_dec = rem_r - CNT_W'(1);
  assign rd_idx  = rem_dec[IDX_W-1:0];

  assign dig_we = (state_r == ST_DIV) && have_prev_r;

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    neg_nxt       = neg_r;
    sign_pend_nxt = sign_pend_r;
    nd_nxt        = nd_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    // drop a delivered character unless the emitter reloads below
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          neg_nxt       = raw[VALUE_WIDTH-1];
          mag_nxt       = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
          have_prev_nxt = 1'b0;
          nd_nxt        = '0;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        // capture the digit of the previous step, then divide again or stop
        if (have_prev_r) begin
          nd_nxt = nd_r + CNT_W'(1);
        end
        if (have_prev_r && (mag_r == '0)) begin
          rem_nxt       = nd_r + CNT_W'(1);
          sign_pend_nxt = neg_r;
          state_nxt     = ST_EMIT;
        end else begin
          prev_nxt      = mag_r[3:0];
          mag_nxt       = quot;
          have_prev_nxt = 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          if (sign_pend_r) begin
            out_char_nxt  = ASCII_MINUS;
            out_last_nxt  = 1'b0;
            sign_pend_nxt = 1'b0;
          end else begin
            out_char_nxt = ASCII_ZERO + {4'b0000, digits_r[rd_idx]};
            out_last_nxt = (rem_r == CNT_W'(1));
            rem_nxt      = rem_dec;
            if (rem_r == CNT_W'(1)) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mag_r       <= mag_nxt;
    prev_r      <= prev_nxt;
    have_prev_r <= have_prev_nxt;
    neg_r       <= neg_nxt;
    sign_pend_r <= sign_pend_nxt;
    nd_r        <= nd_nxt;
    rem_r       <= rem_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    if (dig_we) begin
      digits_r[nd_r[IDX_W-1:0]] <= new_digit;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

  // a new value always starts with an empty digit store
  a_start_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_DIV) && (nd_r == '0) && !have_prev_r)
    else $error("conversion did not start with an empty digit store");

  // the store never overflows while digits are captured
  a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dig_we |-> (nd_r < CNT_W'(MAX_DIGITS)))
    else $error("digit store overflow");

  // the emitter always has something left to send
  a_emit_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (sign_pend_r || (rem_r != '0)))
    else $error("emitter active with nothing to send");

  // a minus sign is never the final character
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_char_r == ASCII_MINUS)) |-> !out_last_r)
    else $error("minus sign flagged as last character");

endmodule
